// ===== hw/rtl/lru_block_cache_lookup_core_defines.svh =====
// Assertion macros for the cache lookup datapath RTL
`ifndef LRU_BLOCK_CACHE_LOOKUP_CORE_DEFINES_SVH
`define LRU_BLOCK_CACHE_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbc assertion failed");

// next-cycle implication
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbc assertion failed");

`else

`define LBC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/lbc_pkg.sv =====
package lbc_pkg;

	// directory geometry
	localparam int ENTRIES = 32;
	localparam int IDX_W   = $clog2(ENTRIES);

	// field widths
	localparam int SRC_W   = 6;
	localparam int BLK_W   = 24;
	localparam int TAG_W   = SRC_W + BLK_W;
	localparam int STAMP_W = 32;
	localparam int SLOT_W  = 5;
	localparam int CFG_W   = 6;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

	typedef struct packed {
		logic [SRC_W-1:0] source_id;
		logic [BLK_W-1:0] block_number;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              replaced_valid;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request, bump stamp, start scan
		logic issue;   // read entry at scan pointer
		logic commit;  // update directory, load response
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_issue;  // scan pointer at last slot in use
		logic hit_seen;    // a matching entry was found
	} sts_t;

endpackage

// ===== hw/rtl/lbc_ctrl.sv =====
module lbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lbc_pkg::cmd_t cmd,
	input  lbc_pkg::sts_t sts
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_WAIT   = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       rsp_busy;

	// response register still held by the sink
	assign rsp_busy  = rsp_valid_q & rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign req_stall = (state_q != ST_IDLE);

	// sequencer
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue || sts.hit_seen) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!rsp_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// response valid: set on commit, cleared on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/lbc_dpath.sv =====
`include "lru_block_cache_lookup_core_defines.svh"

module lbc_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lbc_pkg::CFG_W-1:0]   cfg_wdata,
	input  lbc_pkg::req_t               req,
	output lbc_pkg::rsp_t               rsp,
	input  lbc_pkg::cmd_t               cmd,
	output lbc_pkg::sts_t               sts
);

	// slot-count register
	logic [lbc_pkg::CFG_W-1:0]   cfg_q;
	logic [lbc_pkg::IDX_W-1:0]   last_idx;

	// request and access stamp
	logic [lbc_pkg::TAG_W-1:0]   tag_q;
	logic [lbc_pkg::STAMP_W-1:0] stamp_q;

	// directory storage
	logic [lbc_pkg::TAG_W-1:0]   tag_mem   [lbc_pkg::ENTRIES];
	logic [lbc_pkg::STAMP_W-1:0] stamp_mem [lbc_pkg::ENTRIES];
	logic [lbc_pkg::ENTRIES-1:0] valid_q;

	// scan pointer and read stage
	logic [lbc_pkg::IDX_W-1:0]   rd_addr_q;
	logic                        rd_vld_s1;
	logic [lbc_pkg::IDX_W-1:0]   rd_idx_s1;
	logic [lbc_pkg::TAG_W-1:0]   tag_s1;
	logic [lbc_pkg::STAMP_W-1:0] stamp_s1;

	// scan results
	logic                        hit_q;
	logic [lbc_pkg::IDX_W-1:0]   hit_idx_q;
	logic                        inv_found_q;
	logic [lbc_pkg::IDX_W-1:0]   inv_idx_q;
	logic                        old_found_q;
	logic [lbc_pkg::IDX_W-1:0]   old_idx_q;
	logic [lbc_pkg::STAMP_W-1:0] old_stamp_q;

	logic                        ent_valid;
	logic                        ent_match;
	logic                        ent_older;
	logic [lbc_pkg::IDX_W-1:0]   victim_idx;

	// clamp slot count into 1..ENTRIES, as a last index
	always_comb begin
		if (cfg_q == '0) begin
			last_idx = '0;
		end else if (32'(cfg_q) > 32'(lbc_pkg::ENTRIES)) begin
			last_idx = lbc_pkg::IDX_W'(lbc_pkg::ENTRIES - 1);
		end else begin
			last_idx = lbc_pkg::IDX_W'(cfg_q - lbc_pkg::CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lbc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// request capture and stamp advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= '0;
		end else if (cmd.load) begin
			stamp_q <= stamp_q + lbc_pkg::STAMP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q <= {req.source_id, req.block_number};
		end
	end

	// scan pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.load) begin
				rd_addr_q <= '0;
			end else if (cmd.issue) begin
				rd_addr_q <= rd_addr_q + lbc_pkg::IDX_W'(1);
			end
		end
	end

	// entry compare on the registered read
	assign ent_valid = valid_q[rd_idx_s1];
	assign ent_match = ent_valid && (tag_s1 == tag_q);
	assign ent_older = $signed(stamp_s1) < $signed(old_stamp_q);

	// victim: hit slot, else first invalid, else oldest
	always_comb begin
		if (hit_q) begin
			victim_idx = hit_idx_q;
		end else if (inv_found_q) begin
			victim_idx = inv_idx_q;
		end else begin
			victim_idx = old_idx_q;
		end
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			inv_found_q <= 1'b0;
			old_found_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q       <= 1'b0;
			inv_found_q <= 1'b0;
			old_found_q <= 1'b0;
		end else if (rd_vld_s1 && !hit_q) begin
			if (ent_match) begin
				hit_q <= 1'b1;
			end else if (!ent_valid) begin
				inv_found_q <= 1'b1;
			end else begin
				old_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !hit_q) begin
			if (ent_match) begin
				hit_idx_q <= rd_idx_s1;
			end else if (!ent_valid) begin
				if (!inv_found_q) begin
					inv_idx_q <= rd_idx_s1;
				end
			end else if (!old_found_q || ent_older) begin
				old_idx_q   <= rd_idx_s1;
				old_stamp_q <= stamp_s1;
			end
		end
	end

	// directory memory: one read, one write port
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			tag_s1    <= tag_mem[rd_addr_q];
			stamp_s1  <= stamp_mem[rd_addr_q];
			rd_idx_s1 <= rd_addr_q;
		end
		if (cmd.commit) begin
			stamp_mem[victim_idx] <= stamp_q;
			if (!hit_q) begin
				tag_mem[victim_idx] <= tag_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			valid_q[victim_idx] <= 1'b1;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp.hit            <= hit_q;
			rsp.slot           <= lbc_pkg::SLOT_W'(victim_idx);
			rsp.replaced_valid <= !hit_q && !inv_found_q;
		end
	end

	assign sts.last_issue = (rd_addr_q == last_idx);
	assign sts.hit_seen   = hit_q;

	`LBC_ASSERT_NOW(a_hit_slot_valid, clk, arst_n, cmd.commit && hit_q, valid_q[hit_idx_q])
	`LBC_ASSERT_NEXT(a_victim_marked, clk, arst_n, cmd.commit, valid_q[$past(victim_idx)])
	`LBC_ASSERT_NEXT(a_stamp_step, clk, arst_n, cmd.load,
		stamp_q == $past(stamp_q) + lbc_pkg::STAMP_W'(1))
	`LBC_ASSERT_NOW(a_miss_has_victim, clk, arst_n, cmd.commit && !hit_q,
		inv_found_q || old_found_q)

endmodule

// ===== hw/rtl/lru_block_cache_lookup_core.sv =====
// Block cache directory lookup, fully associative, LRU by access stamp.
// The scan reads one entry per cycle over the slots in use, and a hit ends it early.
// A new request is taken only once the previous one has committed;
// a response stalled in its register holds back the commit of the next request.
// Reset (async, active low): all entries invalid, stamp zero, slots in use 32.
module lru_block_cache_lookup_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [lbc_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  lbc_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output lbc_pkg::rsp_t             rsp
);

	lbc_pkg::cmd_t cmd;
	lbc_pkg::sts_t sts;

	lbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	lbc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== dv/tb_lru_block_cache_lookup_core.sv =====
`timescale 1ns / 100ps

module tb_lru_block_cache_lookup_core;

	localparam int CYCLE_LIMIT     = 500000;
	localparam int SETTLE_CYCLES   = lbc_pkg::ENTRIES + 8;
	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 148;
	localparam int POOL_MAX        = 48;

	// slot counts per random phase (phase 7 draws its own); the out-of-range values fold onto 1 and 32
	localparam logic [lbc_pkg::CFG_W-1:0] PHASE_COUNTS [PHASES] = '{
		6'd32, 6'd1, 6'd2, 6'd31, 6'd0, 6'd63, 6'd33, 6'd8, 6'd32
	};

	typedef enum logic {
		ROW_LOOKUP,
		ROW_SLOT_COUNT
	} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [lbc_pkg::CFG_W-1:0] count;
		lbc_pkg::req_t             lookup;
		logic                      typed;
		lbc_pkg::rsp_t             want;
	} step_row_t;

	localparam int PLAN_LEN = 24;

	// directed plan: rows with typed=1 carry a hand-written response
	localparam step_row_t PLAN [PLAN_LEN] = '{
		// fresh directory fills from slot 0 upward
		'{ROW_LOOKUP,     6'd0,  '{6'h00, 24'h000000}, 1'b1, '{1'b0, 5'd0, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h00, 24'h000000}, 1'b1, '{1'b1, 5'd0, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h3f, 24'hffffff}, 1'b1, '{1'b0, 5'd1, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h3f, 24'hffffff}, 1'b1, '{1'b1, 5'd1, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h00, 24'hffffff}, 1'b1, '{1'b0, 5'd2, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h3f, 24'h000000}, 1'b1, '{1'b0, 5'd3, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h2a, 24'h555555}, 1'b1, '{1'b0, 5'd4, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h15, 24'haaaaaa}, 1'b1, '{1'b0, 5'd5, 1'b0}},
		// one slot in use: slot 1 drops out of the search
		'{ROW_SLOT_COUNT, 6'd1,  '{6'h00, 24'h000000}, 1'b0, '0},
		'{ROW_LOOKUP,     6'd0,  '{6'h00, 24'h000000}, 1'b1, '{1'b1, 5'd0, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h3f, 24'hffffff}, 1'b1, '{1'b0, 5'd0, 1'b1}},
		'{ROW_LOOKUP,     6'd0,  '{6'h00, 24'h000000}, 1'b1, '{1'b0, 5'd0, 1'b1}},
		// zero slots behaves as one
		'{ROW_SLOT_COUNT, 6'd0,  '{6'h00, 24'h000000}, 1'b0, '0},
		'{ROW_LOOKUP,     6'd0,  '{6'h00, 24'h000000}, 1'b1, '{1'b1, 5'd0, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h01, 24'h000001}, 1'b1, '{1'b0, 5'd0, 1'b1}},
		// oversized count behaves as full; slot 1 kept its tag while out of use
		'{ROW_SLOT_COUNT, 6'd63, '{6'h00, 24'h000000}, 1'b0, '0},
		'{ROW_LOOKUP,     6'd0,  '{6'h3f, 24'hffffff}, 1'b1, '{1'b1, 5'd1, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h07, 24'h000007}, 1'b1, '{1'b0, 5'd6, 1'b0}},
		// two slots, both valid: oldest stamp goes
		'{ROW_SLOT_COUNT, 6'd2,  '{6'h00, 24'h000000}, 1'b0, '0},
		'{ROW_LOOKUP,     6'd0,  '{6'h09, 24'h000009}, 1'b0, '0},
		'{ROW_LOOKUP,     6'd0,  '{6'h3f, 24'hffffff}, 1'b0, '0},
		'{ROW_SLOT_COUNT, 6'd33, '{6'h00, 24'h000000}, 1'b0, '0},
		'{ROW_LOOKUP,     6'd0,  '{6'h00, 24'hffffff}, 1'b1, '{1'b1, 5'd2, 1'b0}},
		'{ROW_LOOKUP,     6'd0,  '{6'h21, 24'h123456}, 1'b0, '0}
	};

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [lbc_pkg::CFG_W-1:0]   cfg_wdata;
	logic                        req_valid;
	logic                        req_stall;
	lbc_pkg::req_t               req;
	logic                        rsp_valid;
	logic                        rsp_stall = 1'b0;
	lbc_pkg::rsp_t               rsp;

	// shadow directory
	logic                        dir_valid  [lbc_pkg::ENTRIES];
	logic [lbc_pkg::SRC_W-1:0]   dir_source [lbc_pkg::ENTRIES];
	logic [lbc_pkg::BLK_W-1:0]   dir_block  [lbc_pkg::ENTRIES];
	logic [lbc_pkg::STAMP_W-1:0] dir_stamp  [lbc_pkg::ENTRIES];
	logic [lbc_pkg::STAMP_W-1:0] stamp_now;
	logic [lbc_pkg::CFG_W-1:0]   slot_count_cfg;

	lbc_pkg::rsp_t pending_rsp_q [$];
	lbc_pkg::rsp_t oldest_rsp;
	int            mismatch_count = 0;
	int            cycle_count = 0;
	bit            quiet_phase = 1'b0;

	lru_block_cache_lookup_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Directory lookup: hit refreshes the stamp, miss fills first free or LRU slot
	function automatic lbc_pkg::rsp_t lookup_directory(input lbc_pkg::req_t r);
		int            n;
		int            i;
		int            victim;
		bit            found;
		lbc_pkg::rsp_t res;

		if (slot_count_cfg == 0)
			n = 1;
		else if (slot_count_cfg > lbc_pkg::ENTRIES)
			n = lbc_pkg::ENTRIES;
		else
			n = slot_count_cfg;
		stamp_now = stamp_now + 1'b1;
		res       = '0;
		found     = 1'b0;
		victim    = 0;

		for (i = 0; i < n && !found; i++) begin
			if (dir_valid[i] && dir_source[i] == r.source_id &&
				dir_block[i] == r.block_number) begin
				found        = 1'b1;
				dir_stamp[i] = stamp_now;
				res.hit      = 1'b1;
				res.slot     = lbc_pkg::SLOT_W'(i);
			end
		end

		if (!found) begin
			// stamps compare as signed, so wrapped stamps count as oldest
			for (i = 0; i < n; i++) begin
				if (!dir_valid[i]) begin
					victim = i;
					break;
				end
				if ($signed(dir_stamp[i]) < $signed(dir_stamp[victim]))
					victim = i;
			end
			res.slot           = lbc_pkg::SLOT_W'(victim);
			res.replaced_valid = dir_valid[victim];
			dir_valid[victim]  = 1'b1;
			dir_stamp[victim]  = stamp_now;
			dir_source[victim] = r.source_id;
			dir_block[victim]  = r.block_number;
		end
		return res;
	endfunction

	// One request transfer, with random idle cycles ahead of it outside the quiet phase
	task automatic send_lookup(input lbc_pkg::req_t r, input logic typed,
		input lbc_pkg::rsp_t want);
		lbc_pkg::rsp_t predicted;

		while (!quiet_phase && $urandom_range(0, 99) < 33) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		// stall is settled mid-cycle; the transfer happens on the next free edge
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
		predicted = lookup_directory(r);
		pending_rsp_q.push_back(typed ? want : predicted);
	endtask

	// Slot count write, only once the block has drained
	task automatic write_slot_count(input logic [lbc_pkg::CFG_W-1:0] count);
		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we    <= 1'b0;
		slot_count_cfg = count;
	endtask

	// Response checker and random back-pressure
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				$error("unexpected response: hit %0d slot %0d replaced_valid %0d",
					rsp.hit, rsp.slot, rsp.replaced_valid);
				mismatch_count++;
			end else begin
				oldest_rsp = pending_rsp_q.pop_front();
				if (rsp.hit !== oldest_rsp.hit) begin
					$error("hit: expected %0d, got %0d", oldest_rsp.hit, rsp.hit);
					mismatch_count++;
				end
				if (rsp.slot !== oldest_rsp.slot) begin
					$error("slot: expected %0d, got %0d", oldest_rsp.slot, rsp.slot);
					mismatch_count++;
				end
				if (rsp.replaced_valid !== oldest_rsp.replaced_valid) begin
					$error("replaced_valid: expected %0d, got %0d",
						oldest_rsp.replaced_valid, rsp.replaced_valid);
					mismatch_count++;
				end
			end
		end
		rsp_stall <= !quiet_phase && ($urandom_range(0, 99) < 33);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus
	initial begin
		lbc_pkg::req_t             pool [POOL_MAX];
		int                        pool_size;
		lbc_pkg::req_t             r;
		logic [lbc_pkg::CFG_W-1:0] count;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		req_valid <= 1'b0;
		req       <= '0;
		for (int i = 0; i < lbc_pkg::ENTRIES; i++) begin
			dir_valid[i]  = 1'b0;
			dir_source[i] = '0;
			dir_block[i]  = '0;
			dir_stamp[i]  = '0;
		end
		stamp_now      = '0;
		slot_count_cfg = lbc_pkg::CFG_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		for (int k = 0; k < PLAN_LEN; k++) begin
			if (PLAN[k].kind == ROW_SLOT_COUNT)
				write_slot_count(PLAN[k].count);
			else
				send_lookup(PLAN[k].lookup, PLAN[k].typed, PLAN[k].want);
		end

		// random phases: mostly reuse of a key pool so hits and LRU evictions mix
		for (int p = 0; p < PHASES; p++) begin
			count = (p == 7) ? lbc_pkg::CFG_W'($urandom_range(3, 30)) : PHASE_COUNTS[p];
			write_slot_count(count);
			quiet_phase <= (p == 3);
			pool_size = $urandom_range(1, POOL_MAX);
			for (int k = 0; k < pool_size; k++) begin
				pool[k].source_id    = lbc_pkg::SRC_W'($urandom);
				pool[k].block_number = lbc_pkg::BLK_W'($urandom);
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 99) < 70) begin
					r = pool[$urandom_range(0, pool_size - 1)];
				end else begin
					r.source_id    = lbc_pkg::SRC_W'($urandom);
					r.block_number = lbc_pkg::BLK_W'($urandom);
					if ($urandom_range(0, 3) == 0)
						pool[$urandom_range(0, pool_size - 1)] = r;
				end
				send_lookup(r, 1'b0, '0);
			end
		end

		// drain, then watch for stray responses
		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
